// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL core
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is held low.
`define GDR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gated delta rule core: check failed");

// Same check with a caller-supplied message.
`define GDR_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== hdl/gdr_pkg.sv =====
// ---------------------------------------------------------------------------
// gdr_pkg
// Sizes, codes, types and arithmetic helpers of the gated delta rule core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdr_pkg;

    localparam int HEADS     = 4;
    localparam int KEY_DIM   = 16;
    localparam int VALUE_DIM = 16;

    localparam int HD_W   = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam int KI_W   = $clog2(KEY_DIM);
    localparam int VI_W   = $clog2(VALUE_DIM);
    localparam int DEPTH  = HEADS * KEY_DIM * VALUE_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ACC_W  = 64;

    // command codes carried in tuser
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic signed [ACC_W-1:0] HALF_LSB = 64'sd2048;
    localparam logic signed [ACC_W-1:0] S32_MAX  = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0] S32_MIN  = -64'sd2147483648;

    // one element written into the operand buffers
    typedef struct packed {
        logic              valid;
        logic [3:0]        element;
        logic signed [13:0] query;
        logic signed [13:0] key;
        logic [12:0]       beta;
        logic [12:0]       decay;
        logic signed [15:0] value;
        logic [12:0]       gate;
    } t_load;

    // read indexes into the operand buffers
    typedef struct packed {
        logic [KI_W-1:0] row_a;
        logic [KI_W-1:0] row_key;
        logic [KI_W-1:0] row_q;
        logic [VI_W-1:0] col;
    } t_rd_idx;

    // operands read from the buffers
    typedef struct packed {
        logic [12:0]        decay;
        logic signed [15:0] kb;
        logic signed [13:0] key;
        logic signed [13:0] query;
        logic signed [17:0] vw;
    } t_operands;

    // floor((x + 2^11) / 2^12)
    function automatic logic signed [ACC_W-1:0] round12(input logic signed [ACC_W-1:0] x);
        return (x + HALF_LSB) >>> 12;
    endfunction

    function automatic logic ovf32(input logic signed [ACC_W-1:0] x);
        return (x > S32_MAX) || (x < S32_MIN);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [31:0] y;
        if (x > S32_MAX) begin
            y = 32'sh7FFFFFFF;
        end else if (x < S32_MIN) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // state memory address of entry (row, col) of a head
    function automatic logic [ADDR_W-1:0] ram_addr(input logic [HD_W-1:0] h,
                                                   input logic [KI_W-1:0] r,
                                                   input logic [VI_W-1:0] c);
        return ADDR_W'((int'(h) * KEY_DIM + int'(r)) * VALUE_DIM + int'(c));
    endfunction

endpackage

// ===== hdl/gated_delta_rule_state_update_core.sv =====
// A run ends by emitting one output word per cycle while i_m_axis_tready is high;
// a clear writes every one of the DEPTH entries of the state memory.
// Throughput is set by the single read and write port of the state memory:
// each column is read twice, once to decay and once to update, one entry a cycle.
// Reset (synchronous, active low) starts a clearing pass over all DEPTH entries (1024)
// of the state memory; no word is accepted until it ends.
// ---------------------------------------------------------------------------
// gated_delta_rule_state_update_core
// Per-head gated delta rule update of a key-by-value state matrix in memory,
// followed by the query readout o = S'^T q.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gated_delta_rule_state_update_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // head, element, query_elem, key_elem, beta_elem, decay_elem, value_elem,
    // write_gate_elem (from bit 0 up), zero fill to 96 bits
    input  logic [95:0] i_s_axis_tdata,
    // command
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // out_head, out_index, out_value (from bit 0 up), zero fill to 40 bits
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // saturated
    output logic        o_m_axis_tuser
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_P1    = 3'd2;
    localparam logic [2:0] ST_P2    = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] r_state, n_state;

    logic [gdr_pkg::HD_W-1:0]   r_head;
    logic [gdr_pkg::VI_W-1:0]   r_col;
    logic [gdr_pkg::KI_W-1:0]   r_row;
    logic                       r_iss;
    logic [gdr_pkg::ADDR_W-1:0] r_clr;
    logic [gdr_pkg::VI_W-1:0]   r_oidx;
    logic                       r_sat;

    // pipeline valids and row tags
    logic r_va, r_vb, r_vc, r_vd;
    logic [gdr_pkg::KI_W-1:0] r_ra, r_rb, r_rc, r_rd;

    logic signed [47:0] r_bx;
    logic signed [31:0] r_bd;
    logic signed [48:0] r_cx;
    logic signed [31:0] r_ct;
    logic signed [31:0] r_dx;
    logic signed [31:0] r_e;
    logic signed [gdr_pkg::ACC_W-1:0] r_eacc;
    logic signed [gdr_pkg::ACC_W-1:0] r_oacc;
    logic signed [31:0] r_obuf [gdr_pkg::VALUE_DIM];

    logic        in_acc, out_acc, pass2, pipe_empty, head_ok, col_last;
    logic [1:0]  cmd;
    gdr_pkg::t_load     load;
    gdr_pkg::t_rd_idx   idx;
    gdr_pkg::t_operands ops;

    logic                       ram_we, ram_re;
    logic [gdr_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [31:0]                ram_wdata, ram_rdata;

    logic signed [gdr_pkg::ACC_W-1:0] d_full, s_full, e_full, o_full;
    logic signed [31:0]               d_val, s_val;
    logic signed [45:0]               ekd, osq;

    // unpack the input word
    always_comb begin
        cmd          = i_s_axis_tuser;
        in_acc       = i_s_axis_tvalid && o_s_axis_tready;
        out_acc      = o_m_axis_tvalid && i_m_axis_tready;
        load.valid   = in_acc && (cmd == gdr_pkg::CMD_LOAD || cmd == gdr_pkg::CMD_RUN);
        load.element = i_s_axis_tdata[5:2];
        load.query   = i_s_axis_tdata[19:6];
        load.key     = i_s_axis_tdata[33:20];
        load.beta    = i_s_axis_tdata[46:34];
        load.decay   = i_s_axis_tdata[59:47];
        load.value   = i_s_axis_tdata[75:60];
        load.gate    = i_s_axis_tdata[88:76];
        head_ok      = int'(i_s_axis_tdata[1:0]) < gdr_pkg::HEADS;
        pass2        = (r_state == ST_P2);
        pipe_empty   = !r_iss && !r_va && !r_vb && !r_vc && !r_vd;
        col_last     = (r_col == gdr_pkg::VI_W'(gdr_pkg::VALUE_DIM - 1));
        idx.row_a    = r_ra;
        idx.row_key  = pass2 ? r_rb : r_rc;
        idx.row_q    = r_rd;
        idx.col      = r_col;
    end

    gdr_operand_buf u_ops (
        .i_clk  (i_clk),
        .i_load (load),
        .i_idx  (idx),
        .o_ops  (ops)
    );

    // datapath arithmetic of both passes
    always_comb begin
        d_full = gdr_pkg::round12(gdr_pkg::ACC_W'(r_bx));
        d_val  = gdr_pkg::sat32(d_full);
        s_full = gdr_pkg::round12(gdr_pkg::ACC_W'(r_cx) + (gdr_pkg::ACC_W'(r_ct) <<< 4));
        s_val  = gdr_pkg::sat32(s_full);
        ekd    = ops.key * $signed(r_cx[31:0]);
        osq    = r_dx * ops.query;
        e_full = gdr_pkg::round12(r_eacc);
        o_full = gdr_pkg::round12(r_oacc);
    end

    // memory ports: sweep on clear, decayed value in pass one, new state in pass two
    always_comb begin
        ram_re    = r_iss && (r_state == ST_P1 || r_state == ST_P2);
        ram_raddr = gdr_pkg::ram_addr(r_head, r_row, r_col);
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (r_state == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == ST_P1 && r_vb) begin
            ram_we    = 1'b1;
            ram_waddr = gdr_pkg::ram_addr(r_head, r_rb, r_col);
            ram_wdata = d_val;
        end else if (pass2 && r_vc) begin
            ram_we    = 1'b1;
            ram_waddr = gdr_pkg::ram_addr(r_head, r_rc, r_col);
            ram_wdata = s_val;
        end
    end

    gdr_state_ram #(
        .DEPTH (gdr_pkg::DEPTH),
        .WIDTH (32)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && cmd == gdr_pkg::CMD_RUN && head_ok) begin
                    n_state = ST_P1;
                end else if (in_acc && cmd == gdr_pkg::CMD_CLEAR) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (r_clr == gdr_pkg::ADDR_W'(gdr_pkg::DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_P1: begin
                if (pipe_empty) begin
                    n_state = ST_P2;
                end
            end
            ST_P2: begin
                if (pipe_empty) begin
                    n_state = col_last ? ST_EMIT : ST_P1;
                end
            end
            ST_EMIT: begin
                if (out_acc && r_oidx == gdr_pkg::VI_W'(gdr_pkg::VALUE_DIM - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_iss   <= 1'b0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_vc    <= 1'b0;
            r_vd    <= 1'b0;
            r_oidx  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_sat   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_va    <= ram_re;
            r_vb    <= r_va;
            r_vc    <= r_vb;
            r_vd    <= r_vc && pass2;
            // advance the clearing sweep
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            // start a run or a clear
            if (r_state == ST_IDLE && in_acc) begin
                r_clr <= '0;
                r_col <= '0;
                r_row <= '0;
                r_sat <= 1'b0;
                r_iss <= (cmd == gdr_pkg::CMD_RUN) && head_ok;
            end
            // issue one read a cycle over the column
            if (ram_re) begin
                r_row <= r_row + 1'b1;
                if (r_row == gdr_pkg::KI_W'(gdr_pkg::KEY_DIM - 1)) begin
                    r_iss <= 1'b0;
                end
            end
            // gather saturation over the run
            if ((r_state == ST_P1 && r_vb && gdr_pkg::ovf32(d_full)) ||
                (pass2 && r_vc && gdr_pkg::ovf32(s_full)) ||
                (r_state == ST_P1 && pipe_empty && gdr_pkg::ovf32(e_full)) ||
                (pass2 && pipe_empty && gdr_pkg::ovf32(o_full))) begin
                r_sat <= 1'b1;
            end
            // pass change and column step
            if ((r_state == ST_P1 || (pass2 && !col_last)) && pipe_empty) begin
                r_iss <= 1'b1;
                r_row <= '0;
            end
            if (pass2 && pipe_empty) begin
                r_col <= r_col + 1'b1;
            end
            // step the output index
            if (out_acc) begin
                r_oidx <= r_oidx + 1'b1;
                if (r_oidx == gdr_pkg::VI_W'(gdr_pkg::VALUE_DIM - 1)) begin
                    r_oidx <= '0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_acc) begin
            r_head <= gdr_pkg::HD_W'(i_s_axis_tdata[1:0]);
        end
        r_ra <= r_row;
        r_rb <= r_ra;
        r_rc <= r_rb;
        r_rd <= r_rc;
        // stage b: decay product or k*beta times e
        if (pass2) begin
            r_bx <= ops.kb * r_e;
        end else begin
            r_bx <= 48'($signed({1'b0, ops.decay}) * $signed(ram_rdata));
        end
        r_bd <= ram_rdata;
        // stage c: keep decayed value or form the correction terms
        if (pass2) begin
            r_cx <= (49'(r_bd) <<< 12) - 49'(r_bx);
            r_ct <= ops.key * ops.vw;
        end else begin
            r_cx <= 49'(d_val);
        end
        r_dx <= s_val;
        // stage d: accumulate e or o
        if (r_state == ST_P1 && r_vc) begin
            r_eacc <= r_eacc + gdr_pkg::ACC_W'(ekd);
        end
        if (r_vd) begin
            r_oacc <= r_oacc + gdr_pkg::ACC_W'(osq);
        end
        // close a pass
        if (r_state == ST_P1 && pipe_empty) begin
            r_e    <= gdr_pkg::sat32(e_full);
            r_oacc <= '0;
        end
        if (pass2 && pipe_empty) begin
            r_obuf[r_col] <= gdr_pkg::sat32(o_full);
            r_eacc        <= '0;
        end
        if (r_state == ST_IDLE) begin
            r_eacc <= '0;
        end
    end

    // handshakes and output word
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_EMIT);
    assign o_m_axis_tdata  = {2'b00, r_obuf[r_oidx], 4'(r_oidx), 2'(r_head)};
    assign o_m_axis_tlast  = (r_oidx == gdr_pkg::VI_W'(gdr_pkg::VALUE_DIM - 1));
    assign o_m_axis_tuser  = r_sat;

    `GDR_ASSERT(a_no_rw_clash, i_clk, i_rst_n, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    `GDR_ASSERT(a_emit_drained, i_clk, i_rst_n, o_m_axis_tvalid |-> (!r_va && !r_vb && !r_vc && !r_vd))
    `GDR_ASSERT_MSG(a_last_ends_run, i_clk, i_rst_n,
        (out_acc && o_m_axis_tlast) |=> (r_state == ST_IDLE), "run did not end after last word")

endmodule

// ===== hdl/gdr_state_ram.sv =====
// ---------------------------------------------------------------------------
// gdr_state_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdr_state_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/gdr_operand_buf.sv =====
// ---------------------------------------------------------------------------
// gdr_operand_buf
// Per-element operand buffers; forms k*beta and v*w as each word loads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdr_operand_buf (
    input  logic               i_clk,
    input  gdr_pkg::t_load     i_load,
    input  gdr_pkg::t_rd_idx   i_idx,
    output gdr_pkg::t_operands o_ops
);

    logic signed [13:0] r_query [gdr_pkg::KEY_DIM];
    logic signed [13:0] r_key   [gdr_pkg::KEY_DIM];
    logic [12:0]        r_decay [gdr_pkg::KEY_DIM];
    logic signed [15:0] r_kb    [gdr_pkg::KEY_DIM];
    logic signed [17:0] r_vw    [gdr_pkg::VALUE_DIM];

    logic signed [28:0] kb_sum;
    logic signed [30:0] vw_sum;
    logic               key_side;
    logic               val_side;

    // round the two element products to Q12
    always_comb begin
        kb_sum = 29'(i_load.key * $signed({1'b0, i_load.beta})) + 29'sd2048;
        vw_sum = 31'(i_load.value * $signed({1'b0, i_load.gate})) + 31'sd2048;
        key_side = int'(i_load.element) < gdr_pkg::KEY_DIM;
        val_side = int'(i_load.element) < gdr_pkg::VALUE_DIM;
    end

    // store the element where it fits the vector
    always_ff @(posedge i_clk) begin
        if (i_load.valid && key_side) begin
            r_query[gdr_pkg::KI_W'(i_load.element)] <= i_load.query;
            r_key[gdr_pkg::KI_W'(i_load.element)]   <= i_load.key;
            r_decay[gdr_pkg::KI_W'(i_load.element)] <= i_load.decay;
            r_kb[gdr_pkg::KI_W'(i_load.element)]    <= kb_sum[27:12];
        end
        if (i_load.valid && val_side) begin
            r_vw[gdr_pkg::VI_W'(i_load.element)] <= vw_sum[29:12];
        end
    end

    // read indexes: decay and k*beta share row_a, the other buffers have one each
    always_comb begin
        o_ops.decay = r_decay[i_idx.row_a];
        o_ops.kb    = r_kb[i_idx.row_a];
        o_ops.key   = r_key[i_idx.row_key];
        o_ops.query = r_query[i_idx.row_q];
        o_ops.vw    = r_vw[i_idx.col];
    end

endmodule
